>>> rtl/aat_pkg.sv
// Shared types, constants and the arctangent table for the affine angle transform.
// Used by every module in the rtl folder; depends on nothing else.
package aat_pkg;

   localparam int unsigned ANGLE_BITS_DEF = 16;
   localparam int unsigned MAX_ITERS      = 24;
   localparam int unsigned NORM_STAGES    = 5;

   localparam int unsigned CW = 34;   // CORDIC x/y width
   localparam int unsigned ZW = 32;   // binary angle width, 2^32 per turn
   localparam int unsigned MW = 24;   // matrix coefficient width
   localparam int unsigned PW = CW + MW;
   localparam int unsigned NW = 60;   // normalizer width
   localparam int unsigned DW = 2 * MW;

   localparam logic signed [CW-1:0] CORDIC_K    = CW'(652032874);
   localparam logic signed [NW-1:0] NORM_HI     = NW'(64'd1073741824);
   localparam logic [ZW-1:0]        TURN_HALF   = 32'h8000_0000;
   localparam logic [ZW-1:0]        TURN_QUART  = 32'h4000_0000;
   localparam logic [15:0]          DEG_Q7_TURN = 16'd46080;

   typedef enum logic [1:0] {
      REG_COEF_XX = 2'd0,
      REG_COEF_XY = 2'd1,
      REG_COEF_YX = 2'd2,
      REG_COEF_YY = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic valid;
      logic need;   // vector is too large and must be shifted right
      logic zero;   // vector is exactly zero
   } norm_ctl_type;

   function automatic logic [ZW-1:0] atan_entry(input int unsigned idx);
      logic [ZW-1:0] v;
      case (idx)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [NW-1:0] max_mag(input logic signed [NW-1:0] a,
                                             input logic signed [NW-1:0] b);
      logic [NW-1:0] ma;
      logic [NW-1:0] mb;
      ma = a[NW-1] ? NW'(-a) : NW'(a);
      mb = b[NW-1] ? NW'(-b) : NW'(b);
      return (ma > mb) ? ma : mb;
   endfunction

endpackage

>>> rtl/affine_angle_transform_top.sv
// Affine angle transform: each accepted request gives, in order, a one-cycle
// rsp_valid strobe with its angle, rotation and mirror flag.
// Throughput is one request per cycle: all CORDIC cell rows and both normalizers
// are fully pipelined, so busy stays low and the receiver cannot stall results.
// Synchronous active-high reset clears the pipeline valid bits and loads the
// identity matrix into the coefficient registers.
module affine_angle_transform_top #(
   parameter int unsigned ANGLE_BITS = aat_pkg::ANGLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_angle_in,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_angle_out,
   output logic        [15:0] rsp_rotation_deg,
   output logic               rsp_is_mirrored,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic        [3:0]  csr_paddr,
   input  logic        [31:0] csr_pwdata,
   output logic        [31:0] csr_prdata,
   output logic               csr_pready
);

   localparam int unsigned ITERS = (ANGLE_BITS > aat_pkg::MAX_ITERS) ?
                                   aat_pkg::MAX_ITERS : ANGLE_BITS;
   localparam int unsigned LATENCY = 2 * ITERS + 11;
   localparam int unsigned CW = aat_pkg::CW;
   localparam int unsigned ZW = aat_pkg::ZW;
   localparam int unsigned NW = aat_pkg::NW;
   localparam int unsigned PW = aat_pkg::PW;
   localparam int unsigned DW = aat_pkg::DW;
   localparam int unsigned MW = aat_pkg::MW;
   localparam int unsigned NS = aat_pkg::NORM_STAGES;

   // The block never pushes back: a new request can enter every cycle.
   assign busy       = 1'b0;
   assign csr_pready = 1'b1;

   // ---------------------------------------------------------------------
   // Configuration registers. The user must change the matrix only while the
   // block is idle; the block does not enforce this, and the datapath reads the registers directly.
   // ---------------------------------------------------------------------
   logic signed [MW-1:0] coef_xx_ff, coef_xy_ff, coef_yx_ff, coef_yy_ff, rd_val;
   logic csr_wr;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff <= MW'(65536);
         coef_xy_ff <= '0;
         coef_yx_ff <= '0;
         coef_yy_ff <= MW'(65536);
      end else if (csr_wr) begin
         unique case (aat_pkg::reg_index_type'(csr_paddr[3:2]))
            aat_pkg::REG_COEF_XX: coef_xx_ff <= csr_pwdata[MW-1:0];
            aat_pkg::REG_COEF_XY: coef_xy_ff <= csr_pwdata[MW-1:0];
            aat_pkg::REG_COEF_YX: coef_yx_ff <= csr_pwdata[MW-1:0];
            aat_pkg::REG_COEF_YY: coef_yy_ff <= csr_pwdata[MW-1:0];
            default:              coef_xx_ff <= coef_xx_ff;
         endcase
      end
   end

   always_comb begin
      unique case (aat_pkg::reg_index_type'(csr_paddr[3:2]))
         aat_pkg::REG_COEF_XX: rd_val = coef_xx_ff;
         aat_pkg::REG_COEF_XY: rd_val = coef_xy_ff;
         aat_pkg::REG_COEF_YX: rd_val = coef_yx_ff;
         aat_pkg::REG_COEF_YY: rd_val = coef_yy_ff;
         default:              rd_val = coef_xx_ff;
      endcase
   end
   assign csr_prdata = 32'(rd_val);

   // ---------------------------------------------------------------------
   // Entry stage: widen the 16-bit angle to a 32-bit binary angle and fold
   // it into [-90, 90) degrees, starting at -K when it was turned by 180.
   // ---------------------------------------------------------------------
   logic [ZW-1:0] ang_full, ang_fold;
   logic p0_valid_ff;
   logic signed [CW-1:0] p0_x_ff;
   logic [ZW-1:0] p0_z_ff;
   logic front;

   assign ang_full = {req_angle_in, 16'h0000};
   assign front    = (ang_full[31:30] == 2'b00) || (ang_full[31:30] == 2'b11);
   assign ang_fold = front ? ang_full : ang_full - aat_pkg::TURN_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff <= start && !busy;
      end
      p0_x_ff <= front ? aat_pkg::CORDIC_K : -aat_pkg::CORDIC_K;
      p0_z_ff <= ang_fold;
   end

   // Rotation-mode cell row: produces cos and sin of the request angle.
   logic                 rc_valid [ITERS+1];
   logic signed [CW-1:0] rc_x     [ITERS+1];
   logic signed [CW-1:0] rc_y     [ITERS+1];
   logic [ZW-1:0]        rc_z     [ITERS+1];

   assign rc_valid[0] = p0_valid_ff;
   assign rc_x[0]     = p0_x_ff;
   assign rc_y[0]     = '0;
   assign rc_z[0]     = p0_z_ff;

   for (genvar i = 0; i < ITERS; i++) begin : g_rot
      aat_cordic_cell #(.STEP(i), .VECTORING(1'b0), .TAG_W(1)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (rc_valid[i]),
         .in_x     (rc_x[i]),
         .in_y     (rc_y[i]),
         .in_z     (rc_z[i]),
         .in_tag   (1'b0),
         .out_valid(rc_valid[i+1]),
         .out_x    (rc_x[i+1]),
         .out_y    (rc_y[i+1]),
         .out_z    (rc_z[i+1]),
         .out_tag  ()
      );
   end

   // ---------------------------------------------------------------------
   // Matrix product: four registered multiplies, then the two sums.
   // ---------------------------------------------------------------------
   logic signed [PW-1:0] pr_xx_ff, pr_xy_ff, pr_yx_ff, pr_yy_ff;
   logic signed [NW-1:0] rx_ff, ry_ff;
   logic m1_valid_ff, m2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= rc_valid[ITERS];
         m2_valid_ff <= m1_valid_ff;
      end
      pr_xx_ff <= PW'(rc_x[ITERS]) * PW'(coef_xx_ff);
      pr_xy_ff <= PW'(rc_y[ITERS]) * PW'(coef_xy_ff);
      pr_yx_ff <= PW'(rc_x[ITERS]) * PW'(coef_yx_ff);
      pr_yy_ff <= PW'(rc_y[ITERS]) * PW'(coef_yy_ff);
      rx_ff    <= NW'(pr_xx_ff) + NW'(pr_xy_ff);
      ry_ff    <= NW'(pr_yx_ff) + NW'(pr_yy_ff);
   end

   // ---------------------------------------------------------------------
   // Normalizer for the result vector: shift counts 16, 8, 4, 2, 1.
   // ---------------------------------------------------------------------
   aat_pkg::norm_ctl_type nm_ctl [NS+1];
   logic signed [NW-1:0]  nm_x   [NS+1];
   logic signed [NW-1:0]  nm_y   [NS+1];
   aat_pkg::norm_ctl_type n0_ctl_ff;
   logic signed [NW-1:0]  n0_x_ff, n0_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n0_ctl_ff <= '0;
      end else begin
         n0_ctl_ff.valid <= m2_valid_ff;
         n0_ctl_ff.need  <= aat_pkg::max_mag(rx_ff, ry_ff) >= aat_pkg::NORM_HI;
         n0_ctl_ff.zero  <= (rx_ff == '0) && (ry_ff == '0);
      end
      n0_x_ff <= rx_ff;
      n0_y_ff <= ry_ff;
   end

   assign nm_ctl[0] = n0_ctl_ff;
   assign nm_x[0]   = n0_x_ff;
   assign nm_y[0]   = n0_y_ff;

   for (genvar k = 0; k < NS; k++) begin : g_norm
      aat_norm_cell #(.SHIFT(16 >> k)) u_norm (
         .clock  (clock),
         .reset  (reset),
         .in_ctl (nm_ctl[k]),
         .in_x   (nm_x[k]),
         .in_y   (nm_y[k]),
         .out_ctl(nm_ctl[k+1]),
         .out_x  (nm_x[k+1]),
         .out_y  (nm_y[k+1])
      );
   end

   // Final single right shift where needed, then move a negative x into the
   // right half plane with a 180 degree offset.
   logic signed [NW-1:0] fx, fy;
   logic                 vf_valid_ff, vf_zero_ff;
   logic signed [CW-1:0] vf_x_ff, vf_y_ff;
   logic [ZW-1:0]        vf_z_ff;

   assign fx = nm_ctl[NS].need ? nm_x[NS] >>> 1 : nm_x[NS];
   assign fy = nm_ctl[NS].need ? nm_y[NS] >>> 1 : nm_y[NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_valid_ff <= 1'b0;
      end else begin
         vf_valid_ff <= nm_ctl[NS].valid;
      end
      vf_zero_ff <= nm_ctl[NS].zero;
      vf_x_ff    <= fx[NW-1] ? CW'(-fx) : CW'(fx);
      vf_y_ff    <= fx[NW-1] ? CW'(-fy) : CW'(fy);
      vf_z_ff    <= fx[NW-1] ? aat_pkg::TURN_HALF : '0;
   end

   // Vectoring-mode cell row: the direction of the transformed vector.
   logic                 vc_valid [ITERS+1];
   logic signed [CW-1:0] vc_x     [ITERS+1];
   logic signed [CW-1:0] vc_y     [ITERS+1];
   logic [ZW-1:0]        vc_z     [ITERS+1];
   logic                 vc_zero  [ITERS+1];

   assign vc_valid[0] = vf_valid_ff;
   assign vc_x[0]     = vf_x_ff;
   assign vc_y[0]     = vf_y_ff;
   assign vc_z[0]     = vf_z_ff;
   assign vc_zero[0]  = vf_zero_ff;

   for (genvar i = 0; i < ITERS; i++) begin : g_vec
      aat_cordic_cell #(.STEP(i), .VECTORING(1'b1), .TAG_W(1)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (vc_valid[i]),
         .in_x     (vc_x[i]),
         .in_y     (vc_y[i]),
         .in_z     (vc_z[i]),
         .in_tag   (vc_zero[i]),
         .out_valid(vc_valid[i+1]),
         .out_x    (vc_x[i+1]),
         .out_y    (vc_y[i+1]),
         .out_z    (vc_z[i+1]),
         .out_tag  (vc_zero[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // Matrix rotation lane. It depends only on the coefficients, so it runs
   // every cycle on the current matrix. Its path matches the request path from
   // the matrix product on, so a result's rotation sees the matrix its product saw.
   // ---------------------------------------------------------------------
   aat_pkg::norm_ctl_type rm_ctl [NS+1];
   logic signed [NW-1:0]  rm_x   [NS+1];
   logic signed [NW-1:0]  rm_y   [NS+1];
   aat_pkg::norm_ctl_type r0_ctl_ff;
   logic signed [NW-1:0]  r0_x_ff, r0_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ctl_ff <= '0;
      end else begin
         r0_ctl_ff.valid <= 1'b1;
         r0_ctl_ff.need  <= 1'b0;
         r0_ctl_ff.zero  <= (coef_xy_ff == '0) && (coef_yy_ff == '0);
      end
      r0_x_ff <= NW'(coef_xy_ff);
      r0_y_ff <= NW'(coef_yy_ff);
   end

   assign rm_ctl[0] = r0_ctl_ff;
   assign rm_x[0]   = r0_x_ff;
   assign rm_y[0]   = r0_y_ff;

   for (genvar k = 0; k < NS; k++) begin : g_rnorm
      aat_norm_cell #(.SHIFT(16 >> k)) u_norm (
         .clock  (clock),
         .reset  (reset),
         .in_ctl (rm_ctl[k]),
         .in_x   (rm_x[k]),
         .in_y   (rm_y[k]),
         .out_ctl(rm_ctl[k+1]),
         .out_x  (rm_x[k+1]),
         .out_y  (rm_y[k+1])
      );
   end

   logic                 rf_valid_ff, rf_zero_ff;
   logic signed [CW-1:0] rf_x_ff, rf_y_ff;
   logic [ZW-1:0]        rf_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= 1'b0;
      end else begin
         rf_valid_ff <= rm_ctl[NS].valid;
      end
      rf_zero_ff <= rm_ctl[NS].zero;
      rf_x_ff    <= rm_x[NS][NW-1] ? CW'(-rm_x[NS]) : CW'(rm_x[NS]);
      rf_y_ff    <= rm_x[NS][NW-1] ? CW'(-rm_y[NS]) : CW'(rm_y[NS]);
      rf_z_ff    <= rm_x[NS][NW-1] ? aat_pkg::TURN_HALF : '0;
   end

   logic                 rv_valid [ITERS+1];
   logic signed [CW-1:0] rv_x     [ITERS+1];
   logic signed [CW-1:0] rv_y     [ITERS+1];
   logic [ZW-1:0]        rv_z     [ITERS+1];
   logic                 rv_zero  [ITERS+1];

   assign rv_valid[0] = rf_valid_ff;
   assign rv_x[0]     = rf_x_ff;
   assign rv_y[0]     = rf_y_ff;
   assign rv_z[0]     = rf_z_ff;
   assign rv_zero[0]  = rf_zero_ff;

   for (genvar i = 0; i < ITERS; i++) begin : g_rvec
      aat_cordic_cell #(.STEP(i), .VECTORING(1'b1), .TAG_W(1)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (rv_valid[i]),
         .in_x     (rv_x[i]),
         .in_y     (rv_y[i]),
         .in_z     (rv_z[i]),
         .in_tag   (rv_zero[i]),
         .out_valid(rv_valid[i+1]),
         .out_x    (rv_x[i+1]),
         .out_y    (rv_y[i+1]),
         .out_z    (rv_z[i+1]),
         .out_tag  (rv_zero[i+1])
      );
   end

   // A zero rotation column has an arctangent of zero. Subtract a quarter
   // turn, then scale to Q9.7 degrees with round half up.
   logic [ZW-1:0] rot_ang;
   logic [47:0]   rot_prod_ff;
   logic [48:0]   rot_round;
   logic [16:0]   rot_deg;
   logic [15:0]   rot_deg_ff;

   assign rot_ang   = (rv_zero[ITERS] ? '0 : rv_z[ITERS]) - aat_pkg::TURN_QUART;
   assign rot_round = {1'b0, rot_prod_ff} + 49'h0_8000_0000;
   assign rot_deg   = rot_round[48:32];

   always_ff @(posedge clock) begin
      rot_prod_ff <= 48'(rot_ang) * 48'(aat_pkg::DEG_Q7_TURN);
      rot_deg_ff  <= (rot_deg >= 17'(aat_pkg::DEG_Q7_TURN)) ? '0 : rot_deg[15:0];
   end

   // Determinant sign, also free running on the current matrix.
   logic signed [DW-1:0] det_a_ff, det_b_ff;
   logic mir_ff;

   always_ff @(posedge clock) begin
      det_a_ff <= DW'(coef_xx_ff) * DW'(coef_yy_ff);
      det_b_ff <= DW'(coef_xy_ff) * DW'(coef_yx_ff);
      mir_ff   <= det_a_ff < det_b_ff;
   end

   // ---------------------------------------------------------------------
   // Output register: round the 32-bit angle half up to 16 bits.
   // ---------------------------------------------------------------------
   logic [ZW:0] ang_round;
   logic               out_valid_ff, out_mir_ff;
   logic signed [15:0] out_angle_ff;
   logic [15:0]        out_rot_ff;

   assign ang_round = {1'b0, vc_z[ITERS]} + 33'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vc_valid[ITERS];
      end
      out_angle_ff <= vc_zero[ITERS] ? '0 : ang_round[31:16];
      out_rot_ff   <= rot_deg_ff;
      out_mir_ff   <= mir_ff;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_angle_out    = out_angle_ff;
   assign rsp_rotation_deg = out_rot_ff;
   assign rsp_is_mirrored  = out_mir_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request did not produce a result after the pipeline latency");

   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rotation_deg < aat_pkg::DEG_Q7_TURN))
      else $error("rotation outside one full turn");

   a_vec_start: assert property (@(posedge clock) disable iff (reset)
      (vc_valid[0] && !vc_zero[0]) |->
         (!vc_x[0][CW-1] && (vc_x[0] < CW'(64'd1073741824))))
      else $error("vectoring input not normalized into the right half plane");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vc_valid[ITERS]))
      else $error("result strobe without a request in the cell row");

endmodule

>>> rtl/aat_cordic_cell.sv
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// Depends on aat_pkg for widths and the arctangent table.
module aat_cordic_cell #(
   parameter int unsigned STEP      = 0,
   parameter bit          VECTORING = 1'b0,
   parameter int unsigned TAG_W     = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [aat_pkg::CW-1:0]  in_x,
   input  logic signed [aat_pkg::CW-1:0]  in_y,
   input  logic        [aat_pkg::ZW-1:0]  in_z,
   input  logic        [TAG_W-1:0]        in_tag,
   output logic                           out_valid,
   output logic signed [aat_pkg::CW-1:0]  out_x,
   output logic signed [aat_pkg::CW-1:0]  out_y,
   output logic        [aat_pkg::ZW-1:0]  out_z,
   output logic        [TAG_W-1:0]        out_tag
);

   logic signed [aat_pkg::CW-1:0] xs, ys, x_in, y_in, x_ff, y_ff;
   logic [aat_pkg::ZW-1:0] z_in, z_ff, at;
   logic [TAG_W-1:0] tag_ff;
   logic valid_ff, up;

   assign xs = in_x >>> STEP;
   assign ys = in_y >>> STEP;
   assign at = aat_pkg::atan_entry(STEP);
   assign up = VECTORING ? ~in_y[aat_pkg::CW-1] : ~in_z[aat_pkg::ZW-1];

   always_comb begin
      if (VECTORING) begin
         x_in = up ? in_x + ys : in_x - ys;
         y_in = up ? in_y - xs : in_y + xs;
         z_in = up ? in_z + at : in_z - at;
      end else begin
         x_in = up ? in_x - ys : in_x + ys;
         y_in = up ? in_y + xs : in_y - xs;
         z_in = up ? in_z - at : in_z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      tag_ff <= in_tag;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_tag   = tag_ff;

endmodule

>>> rtl/aat_norm_cell.sv
// One registered step of the vector normalizer: a right or left shift by SHIFT, or none.
// Depends on aat_pkg for the control struct and magnitude helper.
module aat_norm_cell #(
   parameter int unsigned SHIFT = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  aat_pkg::norm_ctl_type          in_ctl,
   input  logic signed [aat_pkg::NW-1:0]  in_x,
   input  logic signed [aat_pkg::NW-1:0]  in_y,
   output aat_pkg::norm_ctl_type          out_ctl,
   output logic signed [aat_pkg::NW-1:0]  out_x,
   output logic signed [aat_pkg::NW-1:0]  out_y
);

   logic signed [aat_pkg::NW-1:0] rs_x, rs_y, ls_x, ls_y, x_in, y_in, x_ff, y_ff;
   aat_pkg::norm_ctl_type ctl_ff;

   assign rs_x = in_x >>> SHIFT;
   assign rs_y = in_y >>> SHIFT;
   assign ls_x = in_x <<< SHIFT;
   assign ls_y = in_y <<< SHIFT;

   // Right: shift while the result stays at or above the top bound, so a
   // final single shift lands it below. Left: shift while it stays below.
   always_comb begin
      x_in = in_x;
      y_in = in_y;
      if (in_ctl.need) begin
         if (aat_pkg::max_mag(rs_x, rs_y) >= aat_pkg::NORM_HI) begin
            x_in = rs_x;
            y_in = rs_y;
         end
      end else if (aat_pkg::max_mag(ls_x, ls_y) < aat_pkg::NORM_HI) begin
         x_in = ls_x;
         y_in = ls_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;

endmodule

>>> verif/affine_angle_transform_top_tb.sv
// Self-checking testbench for affine_angle_transform_top: predicts angle_out, rotation_deg
// and is_mirrored per request and compares every strobed result in order.
// Depends on rtl/aat_pkg.sv and rtl/affine_angle_transform_top.sv.
`timescale 1ns / 100ps

// Holds the expected transform results and the matrix copy used to predict them.
class angle_scoreboard;
   typedef struct {
      logic signed [15:0] angle_out;
      logic        [15:0] rotation_deg;
      logic               is_mirrored;
   } expected_type;

   expected_type pending_q[$];
   logic signed [23:0] coef[4];
   int unsigned n_iter;
   int errors;

   function new(int unsigned iters);
      n_iter = (iters > 24) ? 24 : iters;
      errors = 0;
      coef[0] = 24'sd65536;
      coef[1] = 24'sd0;
      coef[2] = 24'sd0;
      coef[3] = 24'sd65536;
   endfunction

   // Arithmetic shift right of a 64-bit signed value.
   function automatic longint sra(longint v, int unsigned k);
      return v >>> k;
   endfunction

   function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Vectoring CORDIC direction as a 32-bit binary angle; zero vector gives 0.
   function automatic logic [31:0] direction(longint x, longint y);
      longint mx, xn, z;
      z = 0;
      if (x == 0 && y == 0) return 32'd0;
      mx = (abs64(x) > abs64(y)) ? abs64(x) : abs64(y);
      while (mx >= 64'sd1073741824) begin
         x = sra(x, 1);
         y = sra(y, 1);
         mx = (abs64(x) > abs64(y)) ? abs64(x) : abs64(y);
      end
      while (mx < 64'sd536870912) begin
         x = x * 2;
         y = y * 2;
         mx = mx * 2;
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 64'sd2147483648;
      end
      for (int i = 0; i < n_iter; i++) begin
         if (y >= 0) begin
            xn = x + sra(y, i);
            y = y - sra(x, i);
            z += longint'(aat_pkg::atan_entry(i));
         end else begin
            xn = x - sra(y, i);
            y = y + sra(x, i);
            z -= longint'(aat_pkg::atan_entry(i));
         end
         x = xn;
      end
      return z[31:0];
   endfunction

   function void write_coef(int idx, logic [31:0] value);
      coef[idx] = value[23:0];
   endfunction

   // Records the expected result for one accepted request.
   function void note_request(logic signed [15:0] angle);
      expected_type e;
      logic [31:0] a, dir, rot;
      longint x, y, z, xn, rx, ry, m00, m01, m10, m11;
      logic [63:0] deg, dir_r;
      m00 = coef[0];
      m01 = coef[1];
      m10 = coef[2];
      m11 = coef[3];
      a = {angle, 16'h0000};
      if (a[31:30] == 2'b00 || a[31:30] == 2'b11) begin
         x = 652032874;
      end else begin
         x = -652032874;
         a = a - 32'h8000_0000;
      end
      y = 0;
      z = longint'(signed'(a));
      for (int i = 0; i < n_iter; i++) begin
         if (z >= 0) begin
            xn = x - sra(y, i);
            y = y + sra(x, i);
            z -= longint'(aat_pkg::atan_entry(i));
         end else begin
            xn = x + sra(y, i);
            y = y - sra(x, i);
            z += longint'(aat_pkg::atan_entry(i));
         end
         x = xn;
      end
      rx = x * m00 + y * m01;
      ry = x * m10 + y * m11;
      dir = direction(rx, ry);
      dir_r = (64'(dir) + 64'd32768) >> 16;
      e.angle_out = dir_r[15:0];
      rot = direction(m01, m11) - 32'h4000_0000;
      deg = (64'(rot) * 64'd46080 + 64'h8000_0000) >> 32;
      if (deg >= 64'd46080) deg = 0;
      e.rotation_deg = deg[15:0];
      e.is_mirrored = (m00 * m11 - m01 * m10) < 0;
      pending_q.push_back(e);
   endfunction

   function void check_result(logic signed [15:0] angle_out, logic [15:0] rotation_deg,
                              logic is_mirrored);
      expected_type e;
      if (pending_q.size() == 0) begin
         $error("unexpected result angle_out=%0d", angle_out);
         errors++;
         return;
      end
      e = pending_q.pop_front();
      if (angle_out !== e.angle_out) begin
         $error("angle_out expected %0d actual %0d", e.angle_out, angle_out);
         errors++;
      end
      if (rotation_deg !== e.rotation_deg) begin
         $error("rotation_deg expected %0d actual %0d", e.rotation_deg, rotation_deg);
         errors++;
      end
      if (is_mirrored !== e.is_mirrored) begin
         $error("is_mirrored expected %0b actual %0b", e.is_mirrored, is_mirrored);
         errors++;
      end
   endfunction
endclass

module affine_angle_transform_top_tb;

   localparam int unsigned ITERS   = aat_pkg::ANGLE_BITS_DEF;
   localparam int unsigned LATENCY = 2 * ITERS + 11;
   localparam int N_RANDOM = 1625;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_angle_in = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_angle_out;
   logic        [15:0] rsp_rotation_deg;
   logic               rsp_is_mirrored;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic        [3:0]  csr_paddr = '0;
   logic        [31:0] csr_pwdata = '0;
   logic        [31:0] csr_prdata;
   logic               csr_pready;

   angle_scoreboard sb = new(ITERS);

   affine_angle_transform_top #(.ANGLE_BITS(ITERS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_angle_in(req_angle_in), .rsp_valid(rsp_valid),
      .rsp_angle_out(rsp_angle_out), .rsp_rotation_deg(rsp_rotation_deg),
      .rsp_is_mirrored(rsp_is_mirrored), .csr_psel(csr_psel),
      .csr_penable(csr_penable), .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // The receiver cannot stall, so every strobe is checked at the edge that ends it.
   // A request is noted at the edge where start is high and busy is low.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_angle_out, rsp_rotation_deg, rsp_is_mirrored);
         if (start && !busy) sb.note_request(req_angle_in);
      end
   end

   // APB write: a setup cycle, then an access cycle held until pready.
   task automatic write_coef(aat_pkg::reg_index_type idx, logic signed [23:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 4'(idx) << 2;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_coef(int'(idx), 32'(value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic load_matrix(logic signed [23:0] xx, logic signed [23:0] xy,
                              logic signed [23:0] yx, logic signed [23:0] yy);
      write_coef(aat_pkg::REG_COEF_XX, xx);
      write_coef(aat_pkg::REG_COEF_XY, xy);
      write_coef(aat_pkg::REG_COEF_YX, yx);
      write_coef(aat_pkg::REG_COEF_YY, yy);
   endtask

   // Presents one request and holds start until the block takes it. The task lowers
   // start only when a gap follows, so start never toggles within one step.
   task automatic send_request(logic signed [15:0] angle, bit keep_start);
      int gap;
      req_angle_in <= angle;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      gap = 0;
      if (!keep_start) begin
         // Mostly short gaps, an occasional long one.
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap - 1) @(posedge clock);
      end
   endtask

   // Waits until every outstanding result has been checked, then lets the pipe drain
   // so that the block is idle before any register write.
   task automatic drain();
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic signed [23:0] random_coef();
      case ($urandom_range(0, 5))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return 24'sd0;
         3: return 24'(signed'($urandom_range(0, 131072)) - 65536);
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [15:0] corner_angles[12];
      corner_angles = '{16'sh0000, 16'sh4000, 16'shC000, 16'sh8000, 16'sh7FFF,
                        16'sh3FFF, 16'shBFFF, 16'shC001, 16'sh0001, 16'shFFFF,
                        16'sh2000, 16'shA000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Identity matrix after reset: the angle must come back unchanged.
      foreach (corner_angles[i]) send_request(corner_angles[i], 1'b0);
      drain();

      // Zero matrix gives a zero vector and a zero rotation column.
      load_matrix(24'sd0, 24'sd0, 24'sd0, 24'sd0);
      send_request(16'sh1234, 1'b0);
      send_request(16'sh8000, 1'b0);
      drain();

      // Mirror with extreme coefficients.
      load_matrix(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh800000);
      foreach (corner_angles[i]) if (i < 6) send_request(corner_angles[i], 1'b0);
      drain();

      // Singular matrix: collapses some directions onto the zero vector.
      load_matrix(24'sd65536, 24'sd65536, 24'sd65536, 24'sd65536);
      send_request(16'sh6000, 1'b0);
      send_request(16'shE000, 1'b0);
      drain();

      // Random phases, each with a fresh matrix and some back-to-back bursts.
      for (int phase = 0; phase < 13; phase++) begin
         load_matrix(random_coef(), random_coef(), random_coef(), random_coef());
         for (int n = 0; n < N_RANDOM / 13; n++) begin
            send_request(16'($urandom), $urandom_range(0, 2) != 0);
         end
         start <= 1'b0;
         @(posedge clock);
         drain();
      end

      if (sb.errors == 0) $display("affine_angle_transform_top_tb OK");
      else $display("affine_angle_transform_top_tb NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("affine_angle_transform_top_tb NOT OK");
      $finish;
   end
endmodule
